### rtl/core/murmur2_string_hash_core_assert.svh
// Assertion macros used by the hash core controller.
`ifndef MURMUR2_STRING_HASH_CORE_ASSERT_SVH
`define MURMUR2_STRING_HASH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MHC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mhc_pkg.sv
// Types, constants and helper functions for the MurmurHash2 core.
package mhc_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam logic [31:0] SEED_RESET  = 32'h0000abcd;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_FINAL
   } ctrl_state_type;

   typedef enum logic [1:0] {
      WORD_NONE,
      WORD_TAIL,
      WORD_FULL
   } word_class_type;

   typedef struct packed {
      logic capture;
      logic mix;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } dp_status_type;

   function automatic word_class_type classify(input logic [2:0] nbytes);
      word_class_type cls;
      priority if (nbytes == 3'd0) begin
         cls = WORD_NONE;
      end else if (nbytes < 3'd4) begin
         cls = WORD_TAIL;
      end else begin
         cls = WORD_FULL;
      end
      return cls;
   endfunction

   function automatic logic [31:0] tail_mask(input logic [1:0] nbytes);
      logic [31:0] mask;
      unique case (nbytes)
         2'd1:    mask = 32'h000000ff;
         2'd2:    mask = 32'h0000ffff;
         2'd3:    mask = 32'h00ffffff;
         default: mask = 32'h00000000;
      endcase
      return mask;
   endfunction

endpackage

### rtl/core/mhc_datapath.sv
// Datapath: seed register, key and hash multipliers, running hash, result register.
module mhc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data,
   input  logic [31:0]            req_key_word,
   input  logic [2:0]             req_valid_bytes,
   input  logic                   req_first_item,
   input  logic                   req_last_item,
   input  logic [31:0]            req_key_length,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_hash_value,
   input  mhc_pkg::dp_cmd_type    cmd,
   output mhc_pkg::dp_status_type status
);

   logic [31:0]             seed_ff;
   logic [31:0]             hash_ff;
   logic [31:0]             key_ff;
   logic [31:0]             word_ff;
   logic [1:0]              nbytes_ff;
   mhc_pkg::word_class_type class_ff;
   logic                    last_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_hash_ff;

   logic [31:0] key_a;
   logic [31:0] key_prod;
   logic [31:0] hash_a;
   logic [31:0] hash_b;
   logic [31:0] hash_prod;

   // Key multiplier: first product on the transfer, second in the mix step.
   always_comb begin
      if (cmd.capture) begin
         key_a = req_key_word;
      end else begin
         key_a = key_ff ^ (key_ff >> mhc_pkg::MIX_SHIFT);
      end
      key_prod = key_a * mhc_pkg::MIX_MUL;
   end

   // Hash multiplier, shared by seeding, mixing and finalising.
   always_comb begin
      hash_a = hash_ff;
      hash_b = mhc_pkg::MIX_MUL;
      priority if (cmd.capture) begin
         hash_a = seed_ff;
         hash_b = req_key_length;
      end else if (cmd.mix && class_ff == mhc_pkg::WORD_TAIL) begin
         hash_a = hash_ff ^ (word_ff & mhc_pkg::tail_mask(nbytes_ff));
      end else if (cmd.finish) begin
         hash_a = hash_ff ^ (hash_ff >> mhc_pkg::FIN_SHIFT_A);
      end else begin
         hash_a = hash_ff;
      end
      hash_prod = hash_a * hash_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mhc_pkg::SEED_RESET;
      end else if (csr_write_enable) begin
         seed_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= 32'd0;
         class_ff <= mhc_pkg::WORD_NONE;
         last_ff  <= 1'b0;
      end else if (cmd.capture) begin
         class_ff <= mhc_pkg::classify(req_valid_bytes);
         last_ff  <= req_last_item;
         if (req_first_item) begin
            hash_ff <= hash_prod;
         end
      end else if (cmd.mix) begin
         unique case (class_ff)
            mhc_pkg::WORD_FULL: hash_ff <= hash_prod ^ key_prod;
            mhc_pkg::WORD_TAIL: hash_ff <= hash_prod;
            default:            hash_ff <= hash_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff   <= req_key_word;
         nbytes_ff <= req_valid_bytes[1:0];
         key_ff    <= key_prod;
      end else if (cmd.mix) begin
         key_ff <= key_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hash_ff <= hash_prod ^ (hash_prod >> mhc_pkg::FIN_SHIFT_B);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_value  = rsp_hash_ff;
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/core/mhc_ctrl.sv
// Controller: sequences transfer, mix and finalise steps of the hash core.
module mhc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mhc_pkg::dp_status_type status,
   output mhc_pkg::dp_cmd_type    cmd
);

   `include "murmur2_string_hash_core_assert.svh"

   mhc_pkg::ctrl_state_type state_ff;
   mhc_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.mix     = 1'b0;
      cmd.finish  = 1'b0;
      unique case (state_ff)
         mhc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mhc_pkg::ST_MIX;
            end
         end
         mhc_pkg::ST_MIX: begin
            cmd.mix = 1'b1;
            if (status.last) begin
               state_in = mhc_pkg::ST_FINAL;
            end else begin
               state_in = mhc_pkg::ST_IDLE;
            end
         end
         mhc_pkg::ST_FINAL: begin
            // hold until the result register can take the hash
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = mhc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhc_pkg::ST_IDLE;
         end
      endcase
   end

   `MHC_ASSERT_NEXT(a_transfer_to_mix, clock, reset, req_valid && !req_stall, state_ff == mhc_pkg::ST_MIX, "transfer not followed by mix step")
   `MHC_ASSERT_NEXT(a_mix_last_final, clock, reset, state_ff == mhc_pkg::ST_MIX && status.last, state_ff == mhc_pkg::ST_FINAL, "last word did not finalise")
   `MHC_ASSERT_NEXT(a_mix_to_idle, clock, reset, state_ff == mhc_pkg::ST_MIX && !status.last, state_ff == mhc_pkg::ST_IDLE, "non-last word did not return to idle")
   `MHC_ASSERT_NEXT(a_final_waits, clock, reset, state_ff == mhc_pkg::ST_FINAL && !status.out_free, state_ff == mhc_pkg::ST_FINAL && req_stall, "result dropped while output busy")

endmodule

### rtl/core/murmur2_string_hash_core.sv
// Top level of the streaming 32-bit MurmurHash2 core.
// Streaming MurmurHash2 (32-bit). A key is sent as little-endian words; the
// word flagged first_item seeds the hash with hash_seed * key_length, and the
// word flagged last_item finalises it and produces one hash_value transfer.
// Each word takes a transfer step, then a mix step; a last word adds a
// finalise step, held while a previous result is stalled. No new word is
// taken meanwhile; the running hash recurs through the single hash multiplier.
// The output register lets the core take the next word while a hash waits.
// hash_seed resets to 0xabcd and should be written only while the core is idle.
module murmur2_string_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_key_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_first_item,
   input  logic        req_last_item,
   input  logic [31:0] req_key_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   mhc_pkg::dp_cmd_type    cmd;
   mhc_pkg::dp_status_type status;

   mhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mhc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_key_word     (req_key_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_first_item   (req_first_item),
      .req_last_item    (req_last_item),
      .req_key_length   (req_key_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
